// ===== rtl/core/grr_pkg.sv =====
// Shared types, register codes and the 5x7 font for the glyph rectangle rasterizer.
// No dependencies; every other file of the block imports this package.
package grr_pkg;

  // Fixed widths that follow from the field sizes.
  localparam int unsigned CUR_X_W   = 11;  // cursor column, saturating
  localparam int unsigned CUR_Y_W   = 10;  // cursor row
  localparam int unsigned DOT_X_W   = 12;  // column of a dot, cursor plus offset
  localparam int unsigned DOT_Y_W   = 11;  // row of a dot, cursor plus offset
  localparam int unsigned GLYPH_W   = 40;  // 5 columns of 8 rows
  localparam int unsigned DOT_CNT_W = 6;   // counts the 40 dots of a glyph
  localparam logic [DOT_CNT_W-1:0] LAST_DOT = DOT_CNT_W'(GLYPH_W - 1);
  localparam logic [CUR_X_W-1:0]   CURSOR_X_MAX = '1;
  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd95;
  localparam logic [7:0] FALLBACK_CODE = 8'd63;  // '?'
  localparam int unsigned QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    CFG_TEXT_COLOR       = 2'd0,
    CFG_BACKGROUND_COLOR = 2'd1,
    CFG_SCALE            = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [9:0] start_x;
    logic [9:0] start_y;
  } in_t;

  typedef struct packed {
    logic [9:0]  rect_x;
    logic [9:0]  rect_y;
    logic [3:0]  rect_w;
    logic [3:0]  rect_h;
    logic [15:0] fill_color;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] text_color;
    logic [15:0] background_color;
    logic [3:0]  scale;
  } cfg_t;

  // One character ready for the walker: its dots and where it starts.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [CUR_X_W-1:0] base_x;
    logic [CUR_Y_W-1:0] base_y;
  } job_t;

  // Column bytes of codes 32..95; bit 0 of a byte is the top row.
  localparam logic [7:0] FONT_ROM [64][5] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40}
  };

  // Returns all 40 dots of a character, column 0 in the low byte.
  // Codes outside the font are drawn as a question mark.
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    c   = (code < FIRST_CODE || code > LAST_CODE) ? FALLBACK_CODE : code;
    idx = 6'(c - FIRST_CODE);
    return {FONT_ROM[idx][4], FONT_ROM[idx][3], FONT_ROM[idx][2],
            FONT_ROM[idx][1], FONT_ROM[idx][0]};
  endfunction

endpackage

// ===== rtl/core/grr_front.sv =====
// Front end: accepts characters, keeps the text cursor and looks up the glyph.
// Depends on grr_pkg; feeds jobs into grr_queue.
module grr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grr_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  grr_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output grr_pkg::job_t job_o
);
  import grr_pkg::*;

  logic [CUR_X_W-1:0] cursor_x_q, cursor_x_d;
  logic [CUR_Y_W-1:0] cursor_y_q, cursor_y_d;
  logic [CUR_X_W-1:0] cx;
  logic [CUR_Y_W-1:0] cy;
  logic [6:0]         advance;
  logic [CUR_X_W:0]   adv_sum;
  logic               accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cx = in_data_i.new_string ? CUR_X_W'(in_data_i.start_x) : cursor_x_q;
  assign cy = in_data_i.new_string ? in_data_i.start_y : cursor_y_q;

  // Six dots per character: 4*scale + 2*scale.
  assign advance = {1'b0, cfg_i.scale, 2'b00} + {2'b00, cfg_i.scale, 1'b0};
  assign adv_sum = {1'b0, cx} + (CUR_X_W + 1)'(advance);

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (accept) begin
      cursor_x_d = adv_sum[CUR_X_W] ? CURSOR_X_MAX : adv_sum[CUR_X_W-1:0];
      cursor_y_d = cy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  assign push_o       = accept;
  assign job_o.glyph  = glyph_bits(in_data_i.char_code);
  assign job_o.base_x = cx;
  assign job_o.base_y = cy;

endmodule

// ===== rtl/core/grr_queue.sv =====
// Small job queue between the front end and the dot walker.
// Depends on grr_pkg for the job type and depth.
module grr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  grr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output grr_pkg::job_t job_o
);
  import grr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/grr_back.sv =====
// Back end: walks the 40 dots of a glyph, clips each dot to the screen and
// emits rectangles through a one-deep holding stage and an output register.
// Depends on grr_pkg; takes jobs from grr_queue.
module grr_back #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grr_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  grr_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output grr_pkg::out_t out_data_o
);
  import grr_pkg::*;

  localparam logic [DOT_X_W-1:0] SW = DOT_X_W'(SCREEN_WIDTH);
  localparam logic [DOT_Y_W-1:0] SH = DOT_Y_W'(SCREEN_HEIGHT);

  back_state_e          state_q, state_d;
  logic [GLYPH_W-1:0]   glyph_q;
  logic [DOT_CNT_W-1:0] dot_q;
  logic [DOT_X_W-1:0]   px_q;
  logic [DOT_Y_W-1:0]   py_q;
  logic [CUR_Y_W-1:0]   base_y_q;
  out_t                 pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic               load_job, step, out_free, out_load;
  logic               draw_dot, on_screen, cand_emit;
  logic [DOT_X_W-1:0] x_end, x_room;
  logic [DOT_Y_W-1:0] y_end, y_room;
  out_t               cand;

  assign out_free = !out_valid_q || out_ready_i;

  // Candidate rectangle for the dot under the walker.
  assign draw_dot  = (cfg_i.scale != '0) &&
                     (glyph_q[0] || (cfg_i.background_color != cfg_i.text_color));
  assign on_screen = (px_q < SW) && (py_q < SH);
  assign cand_emit = (state_q == BK_WALK) && draw_dot && on_screen;
  assign x_end     = px_q + DOT_X_W'(cfg_i.scale);
  assign y_end     = py_q + DOT_Y_W'(cfg_i.scale);
  assign x_room    = SW - px_q;
  assign y_room    = SH - py_q;

  always_comb begin
    cand            = '0;
    cand.rect_x     = px_q[9:0];
    cand.rect_y     = py_q[9:0];
    cand.rect_w     = (x_end > SW) ? x_room[3:0] : cfg_i.scale;
    cand.rect_h     = (y_end > SH) ? y_room[3:0] : cfg_i.scale;
    cand.fill_color = glyph_q[0] ? cfg_i.text_color : cfg_i.background_color;
    cand.last       = 1'b0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = BK_WALK;
        end
      end
      BK_WALK: begin
        if (step && dot_q == LAST_DOT) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs and datapath moves.
  always_comb begin
    load_job     = 1'b0;
    step         = 1'b0;
    out_load     = 1'b0;
    out_d        = out_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    unique case (state_q)
      BK_IDLE: begin
        load_job = job_valid_i;
      end
      BK_WALK: begin
        // Stall only when a new rectangle meets a full holding stage and
        // the output register cannot take the held one.
        step = !(cand_emit && pend_valid_q && !out_free);
        if (step && cand_emit) begin
          if (pend_valid_q) begin
            out_load = 1'b1;
            out_d    = pend_q;
          end
          pend_d       = cand;
          pend_valid_d = 1'b1;
        end
      end
      BK_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_load     = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        load_job = 1'b0;
      end
    endcase
  end

  assign pop_o       = load_job;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (load_job) begin
      glyph_q  <= job_i.glyph;
      dot_q    <= '0;
      px_q     <= DOT_X_W'(job_i.base_x);
      py_q     <= DOT_Y_W'(job_i.base_y);
      base_y_q <= job_i.base_y;
    end else if (step) begin
      glyph_q <= glyph_q >> 1;
      dot_q   <= dot_q + 1'b1;
      if (dot_q[2:0] == 3'd7) begin
        px_q <= x_end;
        py_q <= DOT_Y_W'(base_y_q);
      end else begin
        py_q <= y_end;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_dot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_WALK |-> dot_q <= LAST_DOT)
    else $error("dot counter ran past the glyph");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> !pend_valid_q)
    else $error("held rectangle left behind after a character");

  a_rect_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.rect_w != '0 && out_q.rect_h != '0))
    else $error("empty rectangle emitted");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FLUSH && out_load) |=> (out_valid_q && out_q.last))
    else $error("final rectangle not marked last");
`endif

endmodule

// ===== rtl/core/glyph_rect_rasterizer.sv =====
// Top level of the glyph rectangle rasterizer: configuration registers and
// the front end, job queue and dot walker. Depends on grr_pkg, grr_front,
// grr_queue and grr_back.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid_i/in_ready_o  in_data_i  (grr_pkg::in_t)
//   out       output     out_valid_o/out_ready_i out_data_o (grr_pkg::out_t)
//   cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// In the dot walker a character passes through the idle state, which loads
// the job, the walk state, which visits each dot of the 5x8 cell, and the
// flush state, which releases its final rectangle. The flush state is
// entered even when nothing was drawn.
// Reset clears the cursor to (0, 0), sets text color to white, background
// to black and scale to 1. While walking, the walker stalls only when a new
// rectangle meets a full holding stage and a busy output register. The
// queue holds two characters, so the front keeps taking input while the
// walker stalls on a busy output, until the queue is full.
module glyph_rect_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  grr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output grr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i
);
  import grr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic q_full, push, pop, job_valid;
  job_t job_in, job_out;

  // Configuration writes land directly; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEXT_COLOR:       cfg_d.text_color       = cfg_wdata_i;
        CFG_BACKGROUND_COLOR: cfg_d.background_color = cfg_wdata_i;
        CFG_SCALE:            cfg_d.scale            = cfg_wdata_i[3:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_color       <= 16'hFFFF;
      cfg_q.background_color <= 16'h0000;
      cfg_q.scale            <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end moves the cursor as soon as a character is taken, so the
  // next character can be classified while this one is still being drawn.
  grr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  grr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  grr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/grr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the glyph rectangle rasterizer bench: a font copy, register and cursor
// mirrors, and the queue of fill rectangles still due from the block.
// Depends on grr_pkg for the payload structs and the register index enum.
package grr_tb_pkg;
  import grr_pkg::*;

  localparam int unsigned SCREEN_W     = 320;
  localparam int unsigned SCREEN_H     = 240;
  localparam logic [7:0]  CODE_LO      = 8'd32;
  localparam logic [7:0]  CODE_HI      = 8'd95;
  localparam logic [7:0]  CODE_UNKNOWN = 8'd63;  // question mark
  localparam int unsigned DOT_COLS     = 5;
  localparam int unsigned DOT_ROWS     = 8;
  localparam int unsigned ADVANCE      = 6;
  localparam int unsigned CURSOR_LIMIT = 2047;
  localparam int unsigned MAX_REPORTS  = 40;

  // Column bytes of codes 32..95, bit 0 is the top row.
  localparam logic [7:0] DOT_COLUMNS [64][5] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40}
  };

  class glyph_scoreboard;
    logic [15:0] text_color;
    logic [15:0] background_color;
    logic [3:0]  scale;
    logic [10:0] cursor_x;
    logic [9:0]  cursor_y;
    out_t        rects_due[$];
    int unsigned errors;
    int unsigned rects_seen;
    int unsigned chars_seen;

    function new();
      text_color       = 16'hFFFF;
      background_color = 16'h0000;
      scale            = 4'd1;
      cursor_x         = '0;
      cursor_y         = '0;
      errors           = 0;
      rects_seen       = 0;
      chars_seen       = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_TEXT_COLOR:       text_color = value;
        CFG_BACKGROUND_COLOR: background_color = value;
        CFG_SCALE:            scale = value[3:0];
        default: ;
      endcase
    endfunction

    // Queues the rectangles one accepted character draws, then moves the cursor.
    function void note_char(in_t item);
      logic [7:0]  code;
      logic [15:0] colour;
      int unsigned glyph_idx, col, row, px, py, w, h, adv, queued;
      out_t        rect;
      chars_seen++;
      if (item.new_string) begin
        cursor_x = {1'b0, item.start_x};
        cursor_y = item.start_y;
      end
      code = (item.char_code < CODE_LO || item.char_code > CODE_HI) ? CODE_UNKNOWN
                                                                    : item.char_code;
      glyph_idx = code - CODE_LO;
      queued = rects_due.size();
      if (scale != 0) begin
        for (col = 0; col < DOT_COLS; col++) begin
          for (row = 0; row < DOT_ROWS; row++) begin
            if (DOT_COLUMNS[glyph_idx][col][row]) colour = text_color;
            else if (background_color != text_color) colour = background_color;
            else continue;
            px = cursor_x + col * scale;
            py = cursor_y + row * scale;
            if (px >= SCREEN_W || py >= SCREEN_H) continue;
            w = (px + scale > SCREEN_W) ? SCREEN_W - px : scale;
            h = (py + scale > SCREEN_H) ? SCREEN_H - py : scale;
            rect.rect_x     = 10'(px);
            rect.rect_y     = 10'(py);
            rect.rect_w     = 4'(w);
            rect.rect_h     = 4'(h);
            rect.fill_color = colour;
            rect.last       = 1'b0;
            rects_due.push_back(rect);
          end
        end
      end
      if (rects_due.size() > queued) rects_due[rects_due.size() - 1].last = 1'b1;
      adv = cursor_x + ADVANCE * scale;
      cursor_x = (adv > CURSOR_LIMIT) ? 11'(CURSOR_LIMIT) : 11'(adv);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_rect(out_t got);
      out_t want;
      if (rects_due.size() == 0) begin
        report($sformatf("rectangle at (%0d,%0d) arrived with none due",
                         got.rect_x, got.rect_y));
        return;
      end
      want = rects_due.pop_front();
      if (got.rect_x !== want.rect_x)
        report($sformatf("rect %0d rect_x %0d, want %0d", rects_seen, got.rect_x, want.rect_x));
      if (got.rect_y !== want.rect_y)
        report($sformatf("rect %0d rect_y %0d, want %0d", rects_seen, got.rect_y, want.rect_y));
      if (got.rect_w !== want.rect_w)
        report($sformatf("rect %0d rect_w %0d, want %0d", rects_seen, got.rect_w, want.rect_w));
      if (got.rect_h !== want.rect_h)
        report($sformatf("rect %0d rect_h %0d, want %0d", rects_seen, got.rect_h, want.rect_h));
      if (got.fill_color !== want.fill_color)
        report($sformatf("rect %0d fill_color %h, want %h", rects_seen, got.fill_color,
                         want.fill_color));
      if (got.last !== want.last)
        report($sformatf("rect %0d last %b, want %b", rects_seen, got.last, want.last));
      rects_seen++;
    endtask
  endclass

endpackage

// ===== dv/glyph_rect_rasterizer_tb.sv =====
`timescale 1ns / 100ps
// Top of the glyph rectangle rasterizer bench: clock, reset, stimulus tasks and output monitor.
// Depends on grr_pkg, grr_tb_pkg and the glyph_rect_rasterizer RTL.
module glyph_rect_rasterizer_tb;
  import grr_pkg::*;
  import grr_tb_pkg::*;

  // Enough cycles for every character the block can hold to leave the walker.
  localparam int unsigned SETTLE_CYCLES = 200;
  // The slowest correct run stays far below this, even with 40 rectangles per
  // character and half of all output cycles stalled.
  localparam int unsigned CYCLE_LIMIT   = 600_000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned settings_used  = 1;  // reset values count as the first setting

  glyph_scoreboard sb = new();

  glyph_rect_rasterizer #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // All sampling happens right after the rising edge, before any nonblocking
  // update of that edge lands, so every process sees the values that the
  // flops actually captured.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_rect(out_data_o);
  end

  // The receiver stalls at random; a percentage of zero keeps ready high.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or lost rectangle ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d rectangles still due",
               cycle_count, sb.rects_due.size());
      $display("** glyph_rect_rasterizer: FAILED **");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 48 : (mode == IDLE_BOTH) ? 30 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 48 : (mode == IDLE_BOTH) ? 30 : 0;
  endtask

  // Offers one character and returns at the edge where the transaction is
  // accepted. Valid stays high into the next call unless that call idles,
  // so back-to-back characters never drop valid between them.
  task automatic send_char(logic [7:0] code, logic new_str, logic [9:0] sx, logic [9:0] sy);
    in_t item;
    item.char_code  = code;
    item.new_string = new_str;
    item.start_x    = sx;
    item.start_y    = sy;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_char(item);
  endtask

  // Holds the input back until every due rectangle has come, then gives the
  // walker time to finish characters that draw nothing at all.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.rects_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // Writes all three registers; the unused upper bits of the scale write are
  // random, since the block must ignore them.
  task automatic set_registers(logic [15:0] text, logic [15:0] bg, logic [3:0] dot_size);
    write_reg(CFG_TEXT_COLOR, text);
    write_reg(CFG_BACKGROUND_COLOR, bg);
    write_reg(CFG_SCALE, {12'($urandom), dot_size});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random strings: each starts by placing the cursor, then runs on from it.
  // Starts are mostly on screen, some hug the right and bottom edges so that
  // clipping and dropping happen, and some are anywhere in the 10-bit range.
  // Mostly printable codes, with some bytes outside the font; now and then a
  // character in mid-string jumps the cursor.
  task automatic random_text(int unsigned count);
    int unsigned sent, len, k;
    logic [9:0]  sx, sy;
    logic [7:0]  code;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(12, 1);
      case ($urandom_range(3))
        0, 1: begin
          sx = 10'($urandom_range(SCREEN_W - 1));
          sy = 10'($urandom_range(SCREEN_H - 1));
        end
        2: begin
          sx = 10'($urandom_range(SCREEN_W + 8, SCREEN_W - 40));
          sy = 10'($urandom_range(SCREEN_H + 4, SCREEN_H - 30));
        end
        default: begin
          sx = 10'($urandom);
          sy = 10'($urandom);
        end
      endcase
      for (k = 0; k < len && sent < count; k++) begin
        code = ($urandom_range(9) < 7) ? 8'($urandom_range(CODE_HI, CODE_LO)) : 8'($urandom);
        if (k == 0) send_char(code, 1'b1, sx, sy);
        else send_char(code, ($urandom_range(19) == 0), 10'($urandom), 10'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned p, k;
    logic [15:0] text, bg;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: white on black, one pixel per
    // dot. Space draws only background, codes on both sides of the font
    // fall back to the question mark, and cursors at and past the screen
    // edges drop some or all rectangles.
    set_idling(IDLE_NONE);
    send_char(8'h20, 1'b1, 10'd0, 10'd0);       // space at the origin
    send_char(8'h41, 1'b0, 10'd0, 10'd0);       // 'A', cursor runs on
    send_char(8'h00, 1'b0, 10'd0, 10'd0);       // below the font
    send_char(8'h1F, 1'b0, 10'd0, 10'd0);
    send_char(8'h5F, 1'b0, 10'd0, 10'd0);       // last code of the font
    send_char(8'h60, 1'b0, 10'd0, 10'd0);       // first code past the font
    send_char(8'h7E, 1'b0, 10'd0, 10'd0);
    send_char(8'hFF, 1'b0, 10'd0, 10'd0);
    send_char(8'h30, 1'b0, 10'd0, 10'd0);       // '0'
    send_char(8'h23, 1'b1, 10'd319, 10'd239);   // only the corner dot fits
    send_char(8'h41, 1'b1, 10'd320, 10'd0);     // starts off the right edge
    send_char(8'h41, 1'b1, 10'd0, 10'd240);     // starts below the screen
    send_char(8'h7F, 1'b1, 10'd1023, 10'd1023);
    send_char(8'h57, 1'b1, 10'd314, 10'd0);     // 'W' ends one column short of the right edge
    send_char(8'h57, 1'b0, 10'd0, 10'd0);       // next one is fully off screen
    send_char(8'h47, 1'b1, 10'd100, 10'd233);   // bottom row dropped

    // Large dots, black on white: edge dots come out narrowed and shortened.
    wait_drained();
    set_registers(16'h0000, 16'hFFFF, 4'd8);
    set_idling(IDLE_SENDER);
    send_char(8'h41, 1'b1, 10'd316, 10'd236);
    send_char(8'h4D, 1'b1, 10'd0, 10'd0);
    send_char(8'hFF, 1'b0, 10'd0, 10'd0);
    send_char(8'h40, 1'b1, 10'd300, 10'd200);
    send_char(8'h5A, 1'b1, 10'd1023, 10'd0);
    send_char(8'h01, 1'b1, 10'd0, 10'd232);

    // Equal colors: only set dots are drawn.
    wait_drained();
    set_registers(16'hF800, 16'hF800, 4'd2);
    set_idling(IDLE_RECEIVER);
    random_text(40);

    // Zero scale draws nothing and leaves the cursor where it is.
    wait_drained();
    set_registers(16'($urandom), 16'($urandom), 4'd0);
    set_idling(IDLE_BOTH);
    random_text(15);

    // Largest scale: a string long enough to pin the cursor at its limit.
    wait_drained();
    set_registers(16'hFFFF, 16'h0000, 4'd15);
    set_idling(IDLE_NONE);
    send_char(8'h48, 1'b1, 10'd1000, 10'd5);
    for (k = 0; k < 13; k++) send_char(8'($urandom), 1'b0, 10'($urandom), 10'($urandom));
    random_text(20);

    // Random settings in the normal range, one idling pattern each.
    for (p = 0; p < 4; p++) begin
      wait_drained();
      text = 16'($urandom);
      bg   = ($urandom_range(3) == 0) ? text : 16'($urandom);
      set_registers(text, bg, 4'($urandom_range(8, 1)));
      set_idling(idle_mode_e'(p));
      random_text(40);
    end

    wait_drained();
    $display("Drew %0d characters under %0d register settings, scale 0 through 15.",
             sb.chars_seen, settings_used);
    $display("Checked %0d rectangles with %0d mismatches across four idling patterns.",
             sb.rects_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("** glyph_rect_rasterizer: PASSED **");
    end else begin
      $display("** glyph_rect_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
